@@ rtl/flrmh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_pkg: shared constants for the four-lane rotate-multiply hash
// Field widths, hash constants, finalizer shifts and register indexes.
// ----------------------------------------------------------------------------
package flrmh_pkg;

	localparam int DATA_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int MSGLEN_W    = 32;
	localparam int HASH_W      = 64;
	localparam int ROT_W       = 6;
	localparam int APB_ADDR_W  = 6;
	localparam int APB_DATA_W  = 64;
	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [63:0] PHI = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] M1  = 64'h85EBCA77C2B2AE3D;
	localparam logic [63:0] M2  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] M3  = 64'h94D049BB133111EB;

	localparam int SHIFT_A = 29;
	localparam int SHIFT_B = 31;
	localparam int SHIFT_C = 37;
	localparam int SHIFT_D = 41;

	localparam logic [2:0] REG_SEED  = 3'd0;
	localparam logic [2:0] REG_ROT_1 = 3'd1;
	localparam logic [2:0] REG_ROT_2 = 3'd2;
	localparam logic [2:0] REG_ROT_3 = 3'd3;
	localparam logic [2:0] REG_ROT_4 = 3'd4;

	localparam logic [ROT_W-1:0] ROT_1_RST = 6'd23;
	localparam logic [ROT_W-1:0] ROT_2_RST = 6'd47;
	localparam logic [ROT_W-1:0] ROT_3_RST = 6'd13;
	localparam logic [ROT_W-1:0] ROT_4_RST = 6'd37;

endpackage

@@ rtl/flrmh_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_in_if: message word channel
// Valid/ready channel carrying one message word with its count and length.
// ----------------------------------------------------------------------------
interface flrmh_in_if;
	logic                          valid;
	logic                          ready;
	logic [flrmh_pkg::DATA_W-1:0]   data_word;
	logic [flrmh_pkg::COUNT_W-1:0]  byte_count;
	logic                          is_last;
	logic [flrmh_pkg::MSGLEN_W-1:0] message_length;

	modport source (output valid, data_word, byte_count, is_last, message_length,
		input ready);
	modport sink (input valid, data_word, byte_count, is_last, message_length,
		output ready);
endinterface

@@ rtl/flrmh_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_out_if: hash result channel
// Valid/ready channel carrying the finalized hash and the length flag.
// ----------------------------------------------------------------------------
interface flrmh_out_if;
	logic                        valid;
	logic                        ready;
	logic [flrmh_pkg::HASH_W-1:0] hash_value;
	logic                        length_mismatch;

	modport source (output valid, hash_value, length_mismatch, input ready);
	modport sink (input valid, hash_value, length_mismatch, output ready);
endinterface

@@ rtl/four_lane_rotate_multiply_hash_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_rotate_multiply_hash_unit: four-lane rotate-multiply message hash
// All 64-bit products run on one shared 32x32 multiplier.
// A word with bytes takes one product; no new word is accepted until it is done.
// The first word of a message first runs the base product, four lane seeds, then its step.
// The last word is followed by finalizing before the result is valid.
// Reset (arst_n low, asynchronous) restores register defaults and idles.
// ----------------------------------------------------------------------------
module four_lane_rotate_multiply_hash_unit #(
	parameter int LENGTH_BITS = flrmh_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [flrmh_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [flrmh_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [flrmh_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	flrmh_in_if.sink                          item,
	flrmh_out_if.source                       result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_BASE = 3'd2;
	localparam logic [2:0] ST_LANE = 3'd3;
	localparam logic [2:0] ST_WORD = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [LENGTH_BITS-1:0] GROUP_BYTES = LENGTH_BITS'(32);

	function automatic logic [63:0] rotl(input logic [63:0] x,
		input logic [flrmh_pkg::ROT_W-1:0] s);
		return (x << s) | (x >> (7'd64 - {1'b0, s}));
	endfunction

	// Configuration registers
	logic [63:0]                  seed_q;
	logic [flrmh_pkg::ROT_W-1:0]  rot_q [4];

	// Message state
	logic [2:0]                   state_q;
	logic [1:0]                   idx_q;
	logic [1:0]                   step_q;
	logic [1:0]                   sel_q;
	logic                         in_message_q;
	logic                         seed_pend_q;
	logic                         word_pend_q;
	logic                         last_q;
	logic [63:0]                  word_q;
	logic [3:0]                   cnt_q;
	logic [63:0]                  lane_q [4];
	logic [LENGTH_BITS-1:0]       offset_q;
	logic [LENGTH_BITS-1:0]       length_q;

	// Shared multiplier datapath
	logic [63:0]                  a_q;
	logic [63:0]                  acc_q;
	logic [63:0]                  prod_q;
	logic [63:0]                  b_sel;
	logic [31:0]                  mul_a;
	logic [31:0]                  mul_b;
	logic [63:0]                  mul_p;
	logic [63:0]                  mul_res;

	// Output register
	logic                         out_valid_q;
	logic [63:0]                  hash_q;
	logic                         mismatch_q;

	logic                         cfg_wr;
	logic                         accept;
	logic [3:0]                   cnt_in;
	logic [63:0]                  word_in;
	logic [63:0]                  len_wide;
	logic [63:0]                  len_op;
	logic [LENGTH_BITS-1:0]       group_start;
	logic                         full_group;
	logic [1:0]                   lane_sel;
	logic [63:0]                  fold;
	logic [63:0]                  hash_final;
	logic                         mul_done;
	logic                         fin_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	assign result.valid           = out_valid_q;
	assign result.hash_value      = hash_q;
	assign result.length_mismatch = mismatch_q;

	always_comb begin
		case (paddr[5:3])
			flrmh_pkg::REG_SEED:  prdata = seed_q;
			flrmh_pkg::REG_ROT_1: prdata = {58'd0, rot_q[0]};
			flrmh_pkg::REG_ROT_2: prdata = {58'd0, rot_q[1]};
			flrmh_pkg::REG_ROT_3: prdata = {58'd0, rot_q[2]};
			flrmh_pkg::REG_ROT_4: prdata = {58'd0, rot_q[3]};
			default:              prdata = '0;
		endcase
	end

	// Input word: clamp the count and clear the bytes past it.
	always_comb begin
		cnt_in = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
		for (int i = 0; i < 8; i++) begin
			word_in[8*i +: 8] = (i < int'(cnt_in)) ? item.data_word[8*i +: 8] : 8'h00;
		end
		len_wide = {32'd0, item.message_length};
	end

	// Lane choice for the pending word; only full words inside a complete group
	// of the stated length leave lane one.
	always_comb begin
		len_op = '0;
		len_op[LENGTH_BITS-1:0] = length_q;
		group_start = {offset_q[LENGTH_BITS-1:5], 5'd0};
		full_group = (cnt_q == 4'd8) && (length_q >= GROUP_BYTES) &&
			(group_start <= length_q - GROUP_BYTES);
		lane_sel = full_group ? offset_q[4:3] : 2'd0;
		fold = (lane_q[0] ^ lane_q[1]) ^ (lane_q[2] ^ lane_q[3]);
	end

	always_comb begin
		case (state_q)
			ST_LANE: begin
				case (idx_q)
					2'd0:    b_sel = flrmh_pkg::PHI;
					2'd1:    b_sel = flrmh_pkg::M1;
					2'd2:    b_sel = flrmh_pkg::M2;
					default: b_sel = flrmh_pkg::M3;
				endcase
			end
			ST_FIN: begin
				case (idx_q)
					2'd0:    b_sel = flrmh_pkg::M1;
					2'd1:    b_sel = flrmh_pkg::M2;
					default: b_sel = flrmh_pkg::PHI;
				endcase
			end
			default: b_sel = flrmh_pkg::PHI;
		endcase
	end

	// Low 64 bits of a 64x64 product from three 32x32 partial products:
	// lo*lo, then hi*lo and lo*hi shifted up by 32.
	assign mul_a   = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
	assign mul_b   = (step_q == 2'd2) ? b_sel[63:32] : b_sel[31:0];
	assign mul_p   = mul_a * mul_b;
	assign mul_res = acc_q + {prod_q[31:0], 32'd0};
	assign mul_done = (step_q == 2'd3);
	assign hash_final = mul_res ^ (mul_res >> flrmh_pkg::SHIFT_D);

	// The finished hash loads once the previous result has left or is leaving now.
	assign fin_load = (state_q == ST_FIN) && mul_done && (idx_q == 2'd2) &&
		(!out_valid_q || result.ready);

	always_ff @(posedge clk) begin
		if ((state_q == ST_BASE || state_q == ST_LANE || state_q == ST_WORD ||
			state_q == ST_FIN) && !mul_done) begin
			prod_q <= mul_p;
			if (step_q == 2'd1) begin
				acc_q <= prod_q;
			end else if (step_q == 2'd2) begin
				acc_q <= mul_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			rot_q[0] <= flrmh_pkg::ROT_1_RST;
			rot_q[1] <= flrmh_pkg::ROT_2_RST;
			rot_q[2] <= flrmh_pkg::ROT_3_RST;
			rot_q[3] <= flrmh_pkg::ROT_4_RST;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				flrmh_pkg::REG_SEED:  seed_q   <= pwdata;
				flrmh_pkg::REG_ROT_1: rot_q[0] <= pwdata[flrmh_pkg::ROT_W-1:0];
				flrmh_pkg::REG_ROT_2: rot_q[1] <= pwdata[flrmh_pkg::ROT_W-1:0];
				flrmh_pkg::REG_ROT_3: rot_q[2] <= pwdata[flrmh_pkg::ROT_W-1:0];
				flrmh_pkg::REG_ROT_4: rot_q[3] <= pwdata[flrmh_pkg::ROT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_in;
			cnt_q  <= cnt_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			step_q       <= '0;
			sel_q        <= '0;
			in_message_q <= 1'b0;
			seed_pend_q  <= 1'b0;
			word_pend_q  <= 1'b0;
			last_q       <= 1'b0;
			offset_q     <= '0;
			length_q     <= '0;
			a_q          <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				lane_q[i] <= '0;
			end
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != ST_IDLE && state_q != ST_PREP && !mul_done) begin
				step_q <= step_q + 2'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_PREP;
						word_pend_q  <= (cnt_in != 4'd0);
						last_q       <= item.is_last;
						in_message_q <= !item.is_last;
						seed_pend_q  <= !in_message_q;
						if (!in_message_q) begin
							length_q <= len_wide[LENGTH_BITS-1:0];
							offset_q <= '0;
						end
					end
				end
				ST_PREP: begin
					step_q <= 2'd0;
					idx_q  <= 2'd0;
					if (seed_pend_q) begin
						seed_pend_q <= 1'b0;
						a_q         <= len_op;
						state_q     <= ST_BASE;
					end else if (word_pend_q) begin
						word_pend_q <= 1'b0;
						sel_q       <= lane_sel;
						a_q         <= lane_q[lane_sel] ^ rotl(word_q, rot_q[lane_sel]);
						offset_q    <= offset_q + LENGTH_BITS'(cnt_q);
						state_q     <= ST_WORD;
					end else if (last_q) begin
						last_q  <= 1'b0;
						a_q     <= fold ^ (fold >> flrmh_pkg::SHIFT_A);
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BASE: begin
					if (mul_done) begin
						a_q     <= seed_q ^ mul_res;
						step_q  <= 2'd0;
						state_q <= ST_LANE;
					end
				end
				ST_LANE: begin
					if (mul_done) begin
						lane_q[idx_q] <= mul_res;
						step_q        <= 2'd0;
						idx_q         <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_WORD: begin
					if (mul_done) begin
						lane_q[sel_q] <= mul_res;
						state_q       <= ST_PREP;
					end
				end
				ST_FIN: begin
					if (mul_done) begin
						if (idx_q == 2'd0) begin
							a_q    <= mul_res ^ (mul_res >> flrmh_pkg::SHIFT_B);
							idx_q  <= 2'd1;
							step_q <= 2'd0;
						end else if (idx_q == 2'd1) begin
							a_q    <= mul_res ^ (mul_res >> flrmh_pkg::SHIFT_C);
							idx_q  <= 2'd2;
							step_q <= 2'd0;
						end else if (fin_load) begin
							// The previous result has left or is leaving now.
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			hash_q     <= hash_final;
			mismatch_q <= (offset_q != length_q);
		end
	end

endmodule

@@ rtl/flrmh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_checker: port-level checks for the hash unit
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module flrmh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] hash_value,
	input logic        length_mismatch
);

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// A held result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hash_value) && $stable(length_mismatch))
		else $error("result payload changed while stalled");

	// Each word passes through the prep state, so no transfer follows directly.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item channel ready right after a transfer");

	// Finalizing takes several products, so a new result never appears
	// in the cycle after a word transfer.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too soon after a word transfer");

endmodule

bind four_lane_rotate_multiply_hash_unit flrmh_checker u_flrmh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item.valid),
	.in_ready        (item.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.hash_value      (result.hash_value),
	.length_mismatch (result.length_mismatch)
);
